// ===== rtl/core/ght_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_pkg
// Shared constants and codes for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int Slots   = 256;
  localparam int SerialW = 16;
  localparam int RefW    = 32;

  localparam int IdxW = $clog2(Slots);
  localparam int CntW = $clog2(Slots + 1);
  localparam int CmdW = 3;
  localparam int StsW = 2;

  // occupancy search: groups of GrpW bits, two-level find-first
  localparam int GrpW    = 16;
  localparam int GrpBitW = $clog2(GrpW);
  localparam int NGrpRaw = (Slots + GrpW - 1) / GrpW;
  localparam int NGrp    = (NGrpRaw < 2) ? 2 : NGrpRaw;
  localparam int GrpIdxW = $clog2(NGrp);
  localparam int PadW    = NGrp * GrpW;

  localparam int MemW = SerialW + RefW;

  localparam logic [CmdW-1:0] CmdAdd       = 3'd0;
  localparam logic [CmdW-1:0] CmdRemove    = 3'd1;
  localparam logic [CmdW-1:0] CmdLookupIdx = 3'd2;
  localparam logic [CmdW-1:0] CmdLookupHdl = 3'd3;
  localparam logic [CmdW-1:0] CmdNext      = 3'd4;
  localparam logic [CmdW-1:0] CmdRemoveAll = 3'd5;

  localparam logic [StsW-1:0] StsOk        = 2'd0;
  localparam logic [StsW-1:0] StsNone      = 2'd1;
  localparam logic [StsW-1:0] StsFull      = 2'd2;
  localparam logic [StsW-1:0] StsBadRemove = 2'd3;

endpackage

// ===== rtl/core/ght_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/generational_handle_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map handing out (index, serial) handles; one item in flight at a time.
// ----------------------------------------------------------------------------
// Sequence: remove, lookups, remove-all and undefined codes pass StFind, then
//   StDone; add and next pass StFind, StPick, StDone (find-first, second RAM read).
// Items: no new item is taken until the last one leaves StDone (held there by a
//   stalled, full output register); a new item is taken while a result waits.
// Reset: occupancy, serial-valid flops, high-water mark and count clear at
//   once; no clearing pass, the block is ready the first cycle after reset.
module generational_handle_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ght_pkg::CmdW-1:0] command_i,
  input  logic [ght_pkg::IdxW-1:0] slot_index_i,
  input  logic [ght_pkg::SerialW-1:0] handle_serial_i,
  input  logic [ght_pkg::RefW-1:0] entity_ref_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ght_pkg::StsW-1:0] status_o,
  output logic [ght_pkg::IdxW-1:0] found_index_o,
  output logic [ght_pkg::SerialW-1:0] found_serial_o,
  output logic [ght_pkg::RefW-1:0] ref_out_o,
  output logic [ght_pkg::CntW-1:0] live_count_o
);
  import ght_pkg::*;

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;  // waiting for an input transfer
  localparam logic [1:0] StFind = 2'd1;  // RAM data for slot_index back; build search vector
  localparam logic [1:0] StPick = 2'd2;  // find-first, read the chosen slot
  localparam logic [1:0] StDone = 2'd3;  // write back, load the output register

  logic [1:0] state_q, state_d;

  // control state
  logic [Slots-1:0] used_q;      // occupancy bits
  logic [Slots-1:0] ser_vld_q;   // serial written since last clear (else reads 0)
  logic [CntW-1:0]  hw_q;        // high-water mark
  logic [CntW-1:0]  cnt_q;       // live count
  logic             out_valid_q;

  // captured item
  logic [CmdW-1:0]    cmd_q;
  logic [IdxW-1:0]    idx_q;
  logic [SerialW-1:0] ser_q;
  logic [RefW-1:0]    ref_q;

  // search pipeline
  logic [NGrp-1:0][GrpW-1:0] cand_q;
  logic [PadW-1:0]           cand_d;
  logic [NGrp-1:0]           grp_any_q, grp_any_d;
  logic                      hv_q;      // handle named an occupied slot, serial matched
  logic                      found_q;   // find-first hit
  logic [IdxW-1:0]           tgt_q;     // slot chosen by add or next

  // output register payload
  logic [StsW-1:0]    sts_q;
  logic [IdxW-1:0]    oidx_q;
  logic [SerialW-1:0] oser_q;
  logic [RefW-1:0]    oref_q;
  logic [CntW-1:0]    ocnt_q;

  // handshakes
  logic in_xfer, out_xfer, done_go;
  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  // finish only when the output register is free or empties this cycle
  assign done_go    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------------
  // Slot RAM: {reference, serial} per slot, one read and one write port
  // ---------------------------------------------------------------------------
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [MemW-1:0] ram_wdata, ram_rdata;
  logic            rd_vld_q;
  logic [SerialW-1:0] rd_ser;
  logic [RefW-1:0]    rd_ref;

  ght_ram #(
    .Width (MemW),
    .Depth (Slots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // serial of a slot never written since reset or remove-all reads as zero
  assign rd_ser = rd_vld_q ? ram_rdata[SerialW-1:0] : '0;
  assign rd_ref = ram_rdata[MemW-1:SerialW];

  // ---------------------------------------------------------------------------
  // Occupancy of the captured index (index at or above the mark is empty)
  // ---------------------------------------------------------------------------
  logic occ;
  assign occ = (CntW'(idx_q) < hw_q) && used_q[idx_q];

  // ---------------------------------------------------------------------------
  // Search vector (StFind): free slots below the mark for add, occupied slots
  // from the start point for next
  // ---------------------------------------------------------------------------
  logic            hv_d;
  logic [CntW-1:0] start;

  assign hv_d  = occ && (rd_ser == ser_q);
  assign start = hv_d ? (CntW'(idx_q) + CntW'(1)) : '0;

  always_comb begin
    for (int i = 0; i < PadW; i++) begin
      cand_d[i] = 1'b0;
      if (i < Slots) begin
        if (cmd_q == CmdAdd) begin
          cand_d[i] = !used_q[i] && (i < int'(hw_q));
        end else begin
          cand_d[i] = used_q[i] && (i < int'(hw_q)) && (i >= int'(start));
        end
      end
    end
    for (int g = 0; g < NGrp; g++) begin
      grp_any_d[g] = |cand_d[g*GrpW +: GrpW];
    end
  end

  // ---------------------------------------------------------------------------
  // Find-first (StPick): first group with a hit, then first bit inside it
  // ---------------------------------------------------------------------------
  logic [GrpIdxW-1:0]         pick_grp;
  logic [GrpBitW-1:0]         pick_bit;
  logic [GrpW-1:0]            pick_sub;
  logic [GrpIdxW+GrpBitW-1:0] pick_full;
  logic [IdxW-1:0]            pick_idx;
  logic                       pick_any;

  always_comb begin
    pick_grp = '0;
    for (int j = NGrp - 1; j >= 0; j--) begin
      if (grp_any_q[j]) begin
        pick_grp = GrpIdxW'(j);
      end
    end
    pick_sub = cand_q[pick_grp];
    pick_bit = '0;
    for (int k = GrpW - 1; k >= 0; k--) begin
      if (pick_sub[k]) begin
        pick_bit = GrpBitW'(k);
      end
    end
  end

  assign pick_any  = |grp_any_q;
  assign pick_full = {pick_grp, pick_bit};
  assign pick_idx  = pick_full[IdxW-1:0];

  // add with no free slot goes to the slot at the mark
  logic [IdxW-1:0] pick_tgt;
  assign pick_tgt = pick_any ? pick_idx : hw_q[IdxW-1:0];

  assign ram_re    = in_xfer || (state_q == StPick);
  assign ram_raddr = in_xfer ? slot_index_i : pick_tgt;

  // ---------------------------------------------------------------------------
  // Result and state update (StDone)
  // ---------------------------------------------------------------------------
  logic [StsW-1:0]    res_sts;
  logic [IdxW-1:0]    res_idx;
  logic [SerialW-1:0] res_ser;
  logic [RefW-1:0]    res_ref;
  logic [CntW-1:0]    cnt_d, hw_d;
  logic               do_add, do_remove, do_clear;
  logic [SerialW-1:0] new_ser;

  assign new_ser = rd_ser + SerialW'(1);

  always_comb begin
    res_sts   = StsNone;
    res_idx   = '0;
    res_ser   = '0;
    res_ref   = '0;
    do_add    = 1'b0;
    do_remove = 1'b0;
    do_clear  = 1'b0;
    case (cmd_q)
      CmdAdd: begin
        if (!found_q && (hw_q >= CntW'(Slots))) begin
          res_sts = StsFull;
        end else begin
          res_sts = StsOk;
          res_idx = tgt_q;
          res_ser = new_ser;
          res_ref = ref_q;
          do_add  = 1'b1;
        end
      end
      CmdRemove: begin
        if (occ) begin
          res_sts   = StsOk;
          res_idx   = idx_q;
          res_ser   = rd_ser;
          res_ref   = rd_ref;
          do_remove = 1'b1;
        end else begin
          res_sts = StsBadRemove;
        end
      end
      CmdLookupIdx: begin
        if (occ) begin
          res_sts = StsOk;
          res_idx = idx_q;
          res_ser = rd_ser;
          res_ref = rd_ref;
        end
      end
      CmdLookupHdl: begin
        if (hv_q) begin
          res_sts = StsOk;
          res_idx = idx_q;
          res_ser = rd_ser;
          res_ref = rd_ref;
        end
      end
      CmdNext: begin
        if (found_q) begin
          res_sts = StsOk;
          res_idx = tgt_q;
          res_ser = rd_ser;
          res_ref = rd_ref;
        end
      end
      CmdRemoveAll: begin
        res_sts  = StsOk;
        do_clear = 1'b1;
      end
      default: begin
        res_sts = StsNone;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    hw_d  = hw_q;
    if (do_clear) begin
      cnt_d = '0;
      hw_d  = '0;
    end else if (do_add) begin
      cnt_d = cnt_q + CntW'(1);
      if (!found_q) begin
        hw_d = hw_q + CntW'(1);
      end
    end else if (do_remove) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign ram_we    = done_go && do_add;
  assign ram_wdata = {ref_q, new_ser};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StFind;
        end
      end
      StFind: begin
        if (cmd_q == CmdAdd || cmd_q == CmdNext) begin
          state_d = StPick;
        end else begin
          state_d = StDone;
        end
      end
      StPick: begin
        state_d = StDone;
      end
      StDone: begin
        if (done_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      ser_vld_q   <= '0;
      hw_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_go) begin
        hw_q  <= hw_d;
        cnt_q <= cnt_d;
        if (do_clear) begin
          used_q    <= '0;
          ser_vld_q <= '0;
        end else if (do_add) begin
          used_q[tgt_q]    <= 1'b1;
          ser_vld_q[tgt_q] <= 1'b1;
        end else if (do_remove) begin
          used_q[idx_q] <= 1'b0;
        end
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= command_i;
      idx_q <= slot_index_i;
      ser_q <= handle_serial_i;
      ref_q <= entity_ref_i;
    end
    if (ram_re) begin
      rd_vld_q <= ser_vld_q[ram_raddr];
    end
    if (state_q == StFind) begin
      cand_q    <= cand_d;
      grp_any_q <= grp_any_d;
      hv_q      <= hv_d;
    end
    if (state_q == StPick) begin
      found_q <= pick_any;
      tgt_q   <= pick_tgt;
    end
    if (done_go) begin
      sts_q  <= res_sts;
      oidx_q <= res_idx;
      oser_q <= res_ser;
      oref_q <= res_ref;
      ocnt_q <= cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = sts_q;
  assign found_index_o  = oidx_q;
  assign found_serial_o = oser_q;
  assign ref_out_o      = oref_q;
  assign live_count_o   = ocnt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_le_hw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hw_q)
    else $error("live count above high-water mark");

  a_hw_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= CntW'(Slots))
    else $error("high-water mark beyond table");

  a_cnt_matches_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(cnt_q))
    else $error("live count disagrees with occupancy bits");

  a_fail_zero_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StsOk)
      |-> (found_index_o == '0 && found_serial_o == '0 && ref_out_o == '0))
    else $error("failed result carries slot fields");

endmodule

// ===== test/tb_generational_handle_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_table
// Self-checking bench for the generational handle table. A directed table
// covers reset state, field extremes, every command and the corner cases.
// Random traffic follows: mixed sessions, a full-table fill, a long output
// hold-off, and a drain pause. Results are checked against a behavioral
// slot map that is updated on every input transfer.
// ----------------------------------------------------------------------------
module tb_generational_handle_table;
  import ght_pkg::*;

  // command codes the block does not define; they must answer "none"
  localparam logic [CmdW-1:0] CmdUndefLo = 3'd6;
  localparam logic [CmdW-1:0] CmdUndefHi = 3'd7;

  localparam int LongHold = 80;       // cycles of output back-pressure
  localparam int TailWait = 8;        // wait after the drain before the verdict, in cycles
  localparam int LimitNs  = 2_000_000;

  typedef struct packed {
    logic [StsW-1:0]    status;
    logic [IdxW-1:0]    index;
    logic [SerialW-1:0] serial;
    logic [RefW-1:0]    ent;
    logic [CntW-1:0]    count;
  } answer_t;

  // one line of the directed table; want is used only when typed is set
  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [IdxW-1:0]    idx;
    logic [SerialW-1:0] ser;
    logic [RefW-1:0]    ent;
    bit                 typed;
    answer_t            want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CmdW-1:0]     command_i;
  logic [IdxW-1:0]     slot_index_i;
  logic [SerialW-1:0]  handle_serial_i;
  logic [RefW-1:0]     entity_ref_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [StsW-1:0]     status_o;
  logic [IdxW-1:0]     found_index_o;
  logic [SerialW-1:0]  found_serial_o;
  logic [RefW-1:0]     ref_out_o;
  logic [CntW-1:0]     live_count_o;

  // hand-typed expectation travels with the item it belongs to
  bit                  dir_check_en;
  answer_t             dir_answer;

  // behavioral copy of the table
  logic [RefW-1:0]     mdl_ent    [Slots];
  logic [SerialW-1:0]  mdl_serial [Slots];
  bit                  mdl_used   [Slots];
  int                  mdl_high;
  int                  mdl_live;

  answer_t             expected_answers[$];
  int                  mismatches;
  bit                  long_hold;   // raised by stimulus, cleared by the receiver
  bit                  no_idle;     // final stretch runs at full rate

  generational_handle_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .slot_index_i    (slot_index_i),
    .handle_serial_i (handle_serial_i),
    .entity_ref_i    (entity_ref_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .found_serial_o  (found_serial_o),
    .ref_out_o       (ref_out_o),
    .live_count_o    (live_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Slot map behavior
  // --------------------------------------------------------------------------

  function automatic answer_t slot_answer(input int i);
    answer_t a;
    a        = '0;
    a.status = StsOk;
    a.index  = IdxW'(i);
    a.serial = mdl_serial[i];
    a.ent    = mdl_ent[i];
    return a;
  endfunction

  // Applies one command to the behavioral table and returns its answer.
  function automatic answer_t slot_map_apply(input logic [CmdW-1:0] cmd,
                                             input logic [IdxW-1:0] idx,
                                             input logic [SerialW-1:0] ser,
                                             input logic [RefW-1:0] ent);
    answer_t a;
    int      i;
    bit      occ;
    bit      hdl_ok;
    a      = '0;
    occ    = (int'(idx) < mdl_high) && mdl_used[idx];
    hdl_ok = occ && (mdl_serial[idx] == ser);
    case (cmd)
      CmdAdd: begin
        // lowest hole below the mark, else the slot at the mark
        i = 0;
        while (i < mdl_high && mdl_used[i]) i++;
        if (i >= Slots) begin
          a.status = StsFull;
        end else begin
          if (i == mdl_high) mdl_high++;
          mdl_used[i]   = 1'b1;
          mdl_ent[i]    = ent;
          mdl_serial[i] = mdl_serial[i] + 1'b1;   // wraps
          mdl_live++;
          a = slot_answer(i);
        end
      end
      CmdRemove: begin
        if (!occ) begin
          a.status = StsBadRemove;
        end else begin
          mdl_used[idx] = 1'b0;
          mdl_live--;
          a = slot_answer(int'(idx));
        end
      end
      CmdLookupIdx: begin
        if (occ) a = slot_answer(int'(idx));
        else a.status = StsNone;
      end
      CmdLookupHdl: begin
        if (hdl_ok) a = slot_answer(int'(idx));
        else a.status = StsNone;
      end
      CmdNext: begin
        // a bad handle restarts the walk at slot 0
        i = hdl_ok ? int'(idx) + 1 : 0;
        while (i < mdl_high && !mdl_used[i]) i++;
        if (i < mdl_high) a = slot_answer(i);
        else a.status = StsNone;
      end
      CmdRemoveAll: begin
        for (int k = 0; k < Slots; k++) begin
          mdl_used[k]   = 1'b0;
          mdl_serial[k] = '0;
        end
        mdl_high = 0;
        mdl_live = 0;
      end
      default: begin
        a.status = StsNone;
      end
    endcase
    a.count = CntW'(mdl_live);
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: outputs are checked before the input of the same edge is
  // queued, so an early result never meets a fresh expectation.
  // --------------------------------------------------------------------------

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    answer_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0h",
                 $time, status_o);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        flag_field("status", 32'(want.status), 32'(status_o));
        flag_field("found_index", 32'(want.index), 32'(found_index_o));
        flag_field("found_serial", 32'(want.serial), 32'(found_serial_o));
        flag_field("ref_out", 32'(want.ent), 32'(ref_out_o));
        flag_field("live_count", 32'(want.count), 32'(live_count_o));
      end
    end
    if (in_valid_i && !in_stall_o) begin
      // the table state always advances, even on a hand-typed row
      want = slot_map_apply(command_i, slot_index_i, handle_serial_i, entity_ref_i);
      if (dir_check_en) want = dir_answer;
      expected_answers.insert(expected_answers.size(), want);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, calm stretches, and one long hold-off on
  // request so that the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int burst;
    int calm;
    int r;
    out_stall_i = 1'b0;
    burst = 0;
    calm  = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else if (calm > 0) begin
        out_stall_i <= 1'b0;
        calm--;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          burst = $urandom_range(1, 6) - 1;
          out_stall_i <= 1'b1;
        end else begin
          if (r == 3) calm = $urandom_range(20, 60);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Entered and left at a falling edge; holds the payload until the transfer.
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [IdxW-1:0] idx,
                           input logic [SerialW-1:0] ser, input logic [RefW-1:0] ent,
                           input bit chk, input answer_t want);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    slot_index_i    <= idx;
    handle_serial_i <= ser;
    entity_ref_i    <= ent;
    dir_check_en    <= chk;
    dir_answer      <= want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_answers.size() != 0);
  endtask

  // Mostly a live slot below the mark; falls back to any index.
  function automatic logic [IdxW-1:0] pick_slot();
    int i;
    for (int k = 0; k < 8; k++) begin
      i = (mdl_high > 0) ? $urandom_range(0, mdl_high - 1) : 0;
      if (mdl_used[i]) return IdxW'(i);
    end
    return IdxW'($urandom);
  endfunction

  // Well-formed handles with random content, plus some noise: foreign index,
  // random serial, stale serial, extreme references.
  task automatic random_item(input int add_pct);
    logic [CmdW-1:0]    cmd;
    logic [IdxW-1:0]    idx;
    logic [SerialW-1:0] ser;
    logic [RefW-1:0]    ent;
    int                 r;
    idx = pick_slot();
    ser = mdl_serial[idx];
    ent = RefW'($urandom);
    if ($urandom_range(0, 99) < add_pct) begin
      cmd = CmdAdd;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25)      cmd = CmdRemove;
      else if (r < 40) cmd = CmdLookupIdx;
      else if (r < 65) cmd = CmdLookupHdl;
      else if (r < 92) cmd = CmdNext;
      else if (r < 93) cmd = CmdRemoveAll;
      else             cmd = r[0] ? CmdUndefLo : CmdUndefHi;
    end
    r = $urandom_range(0, 9);
    if (r == 0)      idx = IdxW'($urandom);
    else if (r == 1) ser = SerialW'($urandom);
    else if (r == 2) ser = ser - 1'b1;
    if ($urandom_range(0, 31) == 0) ent = ent[0] ? '0 : '1;
    send_item(cmd, idx, ser, ent, 1'b0, '0);
  endtask

  function automatic answer_t ans(input logic [StsW-1:0] sts, input int idx,
                                  input int ser, input logic [RefW-1:0] ent,
                                  input int cnt);
    answer_t a;
    a.status = sts;
    a.index  = IdxW'(idx);
    a.serial = SerialW'(ser);
    a.ent    = ent;
    a.count  = CntW'(cnt);
    return a;
  endfunction

  function automatic row_t dir_row(input logic [CmdW-1:0] cmd, input int idx,
                                   input int ser, input logic [RefW-1:0] ent,
                                   input bit typed, input answer_t want);
    row_t r;
    r.cmd   = cmd;
    r.idx   = IdxW'(idx);
    r.ser   = SerialW'(ser);
    r.ent   = ent;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t rows[$];
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = CmdLookupIdx;
    slot_index_i    = '0;
    handle_serial_i = '0;
    entity_ref_i    = '0;
    dir_check_en    = 1'b0;
    dir_answer      = '0;
    mismatches      = 0;
    long_hold       = 1'b0;
    no_idle         = 1'b0;
    for (int k = 0; k < Slots; k++) begin
      mdl_ent[k]    = '0;
      mdl_serial[k] = '0;
      mdl_used[k]   = 1'b0;
    end
    mdl_high = 0;
    mdl_live = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table after reset
    rows.insert(rows.size(), dir_row(CmdLookupIdx, 0, 0, '0, 1,
                                     ans(StsNone, 0, 0, '0, 0)));
    rows.insert(rows.size(), dir_row(CmdNext, 0, 0, '0, 1, ans(StsNone, 0, 0, '0, 0)));
    rows.insert(rows.size(), dir_row(CmdRemove, 0, 0, '0, 1,
                                     ans(StsBadRemove, 0, 0, '0, 0)));
    rows.insert(rows.size(), dir_row(CmdUndefLo, 255, 'hFFFF, '1, 1,
                                     ans(StsNone, 0, 0, '0, 0)));
    rows.insert(rows.size(), dir_row(CmdUndefHi, 0, 0, '0, 1,
                                     ans(StsNone, 0, 0, '0, 0)));
    // zero reference is stored like any other; then the all-ones extreme
    rows.insert(rows.size(), dir_row(CmdAdd, 0, 0, '0, 1, ans(StsOk, 0, 1, '0, 1)));
    rows.insert(rows.size(), dir_row(CmdAdd, 0, 0, '1, 1, ans(StsOk, 1, 1, '1, 2)));
    rows.insert(rows.size(), dir_row(CmdLookupHdl, 1, 1, '0, 0, '0));
    rows.insert(rows.size(), dir_row(CmdLookupHdl, 1, 'hFFFF, '0, 0, '0));  // wrong serial
    rows.insert(rows.size(), dir_row(CmdLookupIdx, 255, 0, '0, 1,
                                     ans(StsNone, 0, 0, '0, 2)));
    rows.insert(rows.size(), dir_row(CmdLookupIdx, 1, 0, '0, 0, '0));
    rows.insert(rows.size(), dir_row(CmdRemove, 0, 0, '0, 0, '0));
    rows.insert(rows.size(), dir_row(CmdLookupHdl, 0, 1, '0, 0, '0));  // freed, serial matches
    rows.insert(rows.size(), dir_row(CmdNext, 0, 1, '0, 0, '0));       // bad handle: from slot 0
    rows.insert(rows.size(), dir_row(CmdNext, 1, 1, '0, 0, '0));       // nothing after it
    rows.insert(rows.size(), dir_row(CmdAdd, 0, 0, 32'hA5A5_5A5A, 0, '0));  // reuses the hole
    rows.insert(rows.size(), dir_row(CmdRemove, 200, 0, '0, 0, '0));   // above the mark
    rows.insert(rows.size(), dir_row(CmdRemove, 0, 0, '0, 0, '0));
    rows.insert(rows.size(), dir_row(CmdRemove, 0, 0, '0, 0, '0));     // already free
    rows.insert(rows.size(), dir_row(CmdRemoveAll, 7, 7, '1, 1,
                                     ans(StsOk, 0, 0, '0, 0)));
    rows.insert(rows.size(), dir_row(CmdLookupIdx, 0, 0, '0, 1,
                                     ans(StsNone, 0, 0, '0, 0)));
    rows.insert(rows.size(), dir_row(CmdAdd, 0, 0, 32'h1234_5678, 1,
                                     ans(StsOk, 0, 1, 32'h1234_5678, 1)));  // serial restarts

    foreach (rows[k])
      send_item(rows[k].cmd, rows[k].idx, rows[k].ser, rows[k].ent,
                rows[k].typed, rows[k].want);

    // growing mixed session
    repeat (350) random_item(45);

    // sender idles until the pipeline is empty
    wait_drained();

    // long output hold-off while items keep coming: input side must stall
    long_hold = 1'b1;
    repeat (50) random_item(40);

    // fill to capacity, then a few adds that must report full
    while (mdl_live < Slots)
      send_item(CmdAdd, '0, '0, RefW'($urandom), 1'b0, '0);
    repeat (4) send_item(CmdAdd, '0, '0, RefW'($urandom), 1'b0, '0);
    repeat (200) random_item(20);

    // clean slate, then a long mixed session; the last stretch runs unthrottled
    send_item(CmdRemoveAll, '0, '0, '0, 1'b0, '0);
    repeat (350) random_item(35);
    no_idle = 1'b1;
    repeat (200) random_item(35);

    wait_drained();
    repeat (TailWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
